[rtl/core/rgpt_pkg.sv]
`default_nettype none

package rgpt_pkg;

   localparam int MAX_CPUS_DEF      = 8;
   localparam int GEN_BITS_DEF      = 32;
   localparam int NEST_BITS_DEF     = 16;
   localparam int CFG_BITS          = 4;
   localparam int CMD_BITS          = 3;
   localparam int FAULT_BITS        = 2;
   localparam int ACTIVE_CPUS_RESET = 8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_READ_LOCK   = 3'd0,
      CMD_READ_UNLOCK = 3'd1,
      CMD_REGISTER_CB = 3'd2,
      CMD_TICK        = 3'd3,
      CMD_MIGRATE     = 3'd4,
      CMD_REQUEUE     = 3'd5
   } cmd_type;

   typedef enum logic [FAULT_BITS-1:0] {
      FAULT_OK        = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_BAD_CPU   = 2'd3
   } fault_type;

endpackage

`default_nettype wire

[rtl/core/rcu_grace_period_tracker.sv]
// channel   direction  handshake                  payload
// req_      in         req_valid / req_stall      command, cpu, dst_cpu, task_nesting,
//                                                 requeue_generation
// rsp_      out        rsp_valid / rsp_stall      gp_generation, gp_ongoing,
//                                                 completed_generation, callback_generation,
//                                                 submit_callbacks, period_done, fault
// csr_      in         csr_valid / csr_ready      active_cpus
//
// One request per cycle while the output register is not held. A request is captured in the
// input register, evaluated against the tracker state in one pass and its response lands in
// the output register. rsp_stall holds the output register, and the input register then
// stalls req_. Synchronous reset: idle tracker, generation 0, active_cpus 8.
`default_nettype none

module rcu_grace_period_tracker #(
   parameter int  MAX_CPUS  = rgpt_pkg::MAX_CPUS_DEF,
   parameter int  GEN_BITS  = rgpt_pkg::GEN_BITS_DEF,
   parameter int  NEST_BITS = rgpt_pkg::NEST_BITS_DEF,
   localparam int CPU_W     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [rgpt_pkg::CMD_BITS-1:0]    req_command,
   input  wire  [CPU_W-1:0]                 req_cpu,
   input  wire  [CPU_W-1:0]                 req_dst_cpu,
   input  wire  [NEST_BITS-1:0]             req_task_nesting,
   input  wire  [GEN_BITS-1:0]              req_requeue_generation,

   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [GEN_BITS-1:0]              rsp_gp_generation,
   output logic                             rsp_gp_ongoing,
   output logic [GEN_BITS-1:0]              rsp_completed_generation,
   output logic [GEN_BITS-1:0]              rsp_callback_generation,
   output logic                             rsp_submit_callbacks,
   output logic                             rsp_period_done,
   output logic [rgpt_pkg::FAULT_BITS-1:0]  rsp_fault,

   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [rgpt_pkg::CFG_BITS-1:0]    csr_active_cpus
);

   localparam int NW = ($clog2(MAX_CPUS + 1) > rgpt_pkg::CFG_BITS) ?
                       $clog2(MAX_CPUS + 1) : rgpt_pkg::CFG_BITS;

   // input register
   logic                          stage_valid_ff;
   logic [rgpt_pkg::CMD_BITS-1:0] cmd_ff;
   logic [CPU_W-1:0]              cpu_ff;
   logic [CPU_W-1:0]              dst_ff;
   logic [NEST_BITS-1:0]          nest_ff;
   logic [GEN_BITS-1:0]           requeue_ff;

   // tracker state
   logic [rgpt_pkg::CFG_BITS-1:0] active_cpus_ff;
   logic [GEN_BITS-1:0]           generation_ff,  generation_in;
   logic                          period_ff,      period_in;
   logic [GEN_BITS-1:0]           last_ff,        last_in;
   logic [MAX_CPUS-1:0]           mask_ff,        mask_in;
   logic                          owes_ff     [MAX_CPUS];
   logic                          owes_in     [MAX_CPUS];
   logic [NEST_BITS-1:0]          depth_ff    [MAX_CPUS];
   logic [NEST_BITS-1:0]          depth_in    [MAX_CPUS];
   logic                          hascb_ff    [MAX_CPUS];
   logic                          hascb_in    [MAX_CPUS];
   logic [GEN_BITS-1:0]           earliest_ff [MAX_CPUS];
   logic [GEN_BITS-1:0]           earliest_in [MAX_CPUS];

   // output register
   logic                          rsp_valid_ff;
   logic [GEN_BITS-1:0]           cb_gen_ff,  cb_gen_in;
   logic                          submit_ff,  submit_in;
   logic                          done_ff,    done_in;
   logic [rgpt_pkg::FAULT_BITS-1:0] fault_ff;
   rgpt_pkg::fault_type           fault_in;

   logic                          advance;
   logic                          accept;
   logic [NW-1:0]                 cpus_raw;
   logic [NW-1:0]                 n_cpus;
   logic [MAX_CPUS-1:0]           abits;
   logic                          bad_cpu;
   logic                          ow;
   logic                          hc;
   logic [NEST_BITS-1:0]          dp_c;
   logic [NEST_BITS-1:0]          dp_d;
   logic [GEN_BITS-1:0]           eg;
   logic [NEST_BITS:0]            nest_sum;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign cpus_raw = NW'(active_cpus_ff);

   always_comb begin
      priority if (cpus_raw == '0) begin
         n_cpus = NW'(1);
      end else if (cpus_raw > NW'(MAX_CPUS)) begin
         n_cpus = NW'(MAX_CPUS);
      end else begin
         n_cpus = cpus_raw;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CPUS; i++) begin
         abits[i] = (NW'(i) < n_cpus);
      end
   end

   assign bad_cpu = (cmd_ff <= rgpt_pkg::CMD_REQUEUE) &&
                    ((NW'(cpu_ff) >= n_cpus) ||
                     ((cmd_ff == rgpt_pkg::CMD_MIGRATE) && (NW'(dst_ff) >= n_cpus)));

   always_comb begin
      generation_in = generation_ff;
      period_in     = period_ff;
      last_in       = last_ff;
      mask_in       = mask_ff;
      owes_in       = owes_ff;
      depth_in      = depth_ff;
      hascb_in      = hascb_ff;
      earliest_in   = earliest_ff;
      cb_gen_in     = '0;
      submit_in     = 1'b0;
      done_in       = 1'b0;
      fault_in      = rgpt_pkg::FAULT_OK;
      ow            = 1'b0;
      hc            = 1'b0;
      dp_c          = '0;
      dp_d          = '0;
      eg            = '0;
      nest_sum      = '0;

      if (bad_cpu) begin
         fault_in = rgpt_pkg::FAULT_BAD_CPU;
      end else begin
         unique case (cmd_ff)
            rgpt_pkg::CMD_READ_LOCK: begin
               dp_c = depth_ff[cpu_ff];
               if (dp_c == '1) begin
                  fault_in = rgpt_pkg::FAULT_OVERFLOW;
               end else begin
                  depth_in[cpu_ff] = dp_c + NEST_BITS'(1);
                  if (dp_c == '0 && period_ff && !owes_ff[cpu_ff]) begin
                     owes_in[cpu_ff] = 1'b1;
                     mask_in[cpu_ff] = 1'b1;
                  end
               end
            end
            rgpt_pkg::CMD_READ_UNLOCK: begin
               dp_c = depth_ff[cpu_ff];
               if (dp_c == '0) begin
                  fault_in = rgpt_pkg::FAULT_UNDERFLOW;
               end else begin
                  depth_in[cpu_ff] = dp_c - NEST_BITS'(1);
               end
            end
            rgpt_pkg::CMD_REGISTER_CB: begin
               dp_c      = depth_ff[cpu_ff];
               ow        = owes_ff[cpu_ff];
               cb_gen_in = period_ff ? generation_ff : generation_ff + GEN_BITS'(1);
               if (cb_gen_in < earliest_ff[cpu_ff]) begin
                  earliest_in[cpu_ff] = cb_gen_in;
               end
               hascb_in[cpu_ff] = 1'b1;
               if (!period_ff) begin
                  generation_in = generation_ff + GEN_BITS'(1);
                  period_in     = 1'b1;
                  mask_in       = abits;
                  if (!ow) begin
                     ow = 1'b1;
                     if (dp_c == '0) begin
                        mask_in[cpu_ff] = 1'b0;
                        ow              = 1'b0;
                        if ((mask_in & abits) == '0) begin
                           last_in       = generation_in;
                           generation_in = generation_in + GEN_BITS'(1);
                           period_in     = 1'b0;
                           done_in       = 1'b1;
                        end
                     end
                  end
                  owes_in[cpu_ff] = ow;
               end
            end
            rgpt_pkg::CMD_TICK: begin
               dp_c = depth_ff[cpu_ff];
               ow   = owes_ff[cpu_ff];
               hc   = hascb_ff[cpu_ff];
               eg   = earliest_ff[cpu_ff];
               // quiescent report
               if (ow && dp_c == '0) begin
                  mask_in[cpu_ff] = 1'b0;
                  ow              = 1'b0;
                  if ((mask_in & abits) == '0 && period_in) begin
                     last_in       = generation_in;
                     generation_in = generation_in + GEN_BITS'(1);
                     period_in     = 1'b0;
                     done_in       = 1'b1;
                  end
               end
               // hand out due callbacks
               if (hc && eg <= last_in) begin
                  hc        = 1'b0;
                  eg        = '1;
                  submit_in = 1'b1;
               end
               if (period_in && !ow) begin
                  ow = 1'b1;
                  if (dp_c == '0) begin
                     mask_in[cpu_ff] = 1'b0;
                     ow              = 1'b0;
                     if ((mask_in & abits) == '0) begin
                        last_in       = generation_in;
                        generation_in = generation_in + GEN_BITS'(1);
                        period_in     = 1'b0;
                        done_in       = 1'b1;
                     end
                  end
               end
               // start a new period for callbacks still held
               if (!period_in && hc) begin
                  generation_in = generation_in + GEN_BITS'(1);
                  period_in     = 1'b1;
                  mask_in       = abits;
                  if (!ow) begin
                     ow = 1'b1;
                     if (dp_c == '0) begin
                        mask_in[cpu_ff] = 1'b0;
                        ow              = 1'b0;
                        if ((mask_in & abits) == '0) begin
                           last_in       = generation_in;
                           generation_in = generation_in + GEN_BITS'(1);
                           period_in     = 1'b0;
                           done_in       = 1'b1;
                        end
                     end
                  end
               end
               owes_in[cpu_ff]     = ow;
               hascb_in[cpu_ff]    = hc;
               earliest_in[cpu_ff] = eg;
            end
            rgpt_pkg::CMD_MIGRATE: begin
               dp_c     = depth_ff[cpu_ff];
               dp_d     = depth_ff[dst_ff];
               nest_sum = (NEST_BITS + 1)'(dp_d) + (NEST_BITS + 1)'(nest_ff);
               if (nest_ff != '0) begin
                  priority if (dp_c < nest_ff) begin
                     fault_in = rgpt_pkg::FAULT_UNDERFLOW;
                  end else if (cpu_ff != dst_ff && nest_sum[NEST_BITS]) begin
                     fault_in = rgpt_pkg::FAULT_OVERFLOW;
                  end else begin
                     if (dp_d == '0) begin
                        owes_in[dst_ff] = 1'b1;
                        mask_in[dst_ff] = 1'b1;
                     end
                     if (cpu_ff != dst_ff) begin
                        depth_in[dst_ff] = nest_sum[NEST_BITS-1:0];
                        depth_in[cpu_ff] = dp_c - nest_ff;
                     end
                  end
               end
            end
            rgpt_pkg::CMD_REQUEUE: begin
               if (requeue_ff < earliest_ff[cpu_ff]) begin
                  earliest_in[cpu_ff] = requeue_ff;
               end
               hascb_in[cpu_ff] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (accept) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         cpu_ff     <= req_cpu;
         dst_ff     <= req_dst_cpu;
         nest_ff    <= req_task_nesting;
         requeue_ff <= req_requeue_generation;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cpus_ff <= rgpt_pkg::CFG_BITS'(rgpt_pkg::ACTIVE_CPUS_RESET);
      end else if (csr_valid && csr_ready) begin
         active_cpus_ff <= csr_active_cpus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         generation_ff <= '0;
         period_ff     <= 1'b0;
         last_ff       <= '0;
         mask_ff       <= '0;
         for (int i = 0; i < MAX_CPUS; i++) begin
            owes_ff[i]     <= 1'b0;
            depth_ff[i]    <= '0;
            hascb_ff[i]    <= 1'b0;
            earliest_ff[i] <= '1;
         end
      end else if (advance) begin
         generation_ff <= generation_in;
         period_ff     <= period_in;
         last_ff       <= last_in;
         mask_ff       <= mask_in;
         owes_ff       <= owes_in;
         depth_ff      <= depth_in;
         hascb_ff      <= hascb_in;
         earliest_ff   <= earliest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= advance || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cb_gen_ff <= cb_gen_in;
         submit_ff <= submit_in;
         done_ff   <= done_in;
         fault_ff  <= fault_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_gp_generation        = generation_ff;
   assign rsp_gp_ongoing           = period_ff;
   assign rsp_completed_generation = last_ff;
   assign rsp_callback_generation  = cb_gen_ff;
   assign rsp_submit_callbacks     = submit_ff;
   assign rsp_period_done          = done_ff;
   assign rsp_fault                = fault_ff;

   // a rejected request leaves the tracker untouched
   a_fault_no_change: assert property (@(posedge clock) disable iff (reset)
      (advance && fault_in != rgpt_pkg::FAULT_OK) |=>
         (generation_ff == $past(generation_ff) && period_ff == $past(period_ff) &&
          mask_ff == $past(mask_ff)))
      else $error("state changed on a faulted request");

   // completed generation moves only when a period ends
   a_last_moves_on_done: assert property (@(posedge clock) disable iff (reset)
      (advance && !done_in) |=> (last_ff == $past(last_ff)))
      else $error("completed generation moved without period end");

   // after a completion the generation sits one past it, two if a new period opened
   a_done_generation: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_period_done) |->
         ((!rsp_gp_ongoing && rsp_gp_generation == rsp_completed_generation + GEN_BITS'(1)) ||
          (rsp_gp_ongoing && rsp_gp_generation == rsp_completed_generation + GEN_BITS'(2))))
      else $error("generation inconsistent with completed period");

   // held response keeps the tracker state frozen
   a_hold_freezes_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (generation_ff == $past(generation_ff) &&
                                    last_ff == $past(last_ff)))
      else $error("tracker state moved under a held response");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int          CPUS          = 8;
   localparam int          QUIET_LIMIT   = 2000;
   localparam int          LONG_HOLD     = 60;
   localparam int          SETTLE_CYCLES = 10;
   localparam logic [2:0]  CMD_SPARE_A   = 3'd6;
   localparam logic [2:0]  CMD_SPARE_B   = 3'd7;
   localparam logic [15:0] DEPTH_FULL    = 16'hFFFF;

   typedef struct {
      logic [31:0] gp_generation;
      logic        gp_ongoing;
      logic [31:0] completed_generation;
      logic [31:0] callback_generation;
      logic        submit_callbacks;
      logic        period_done;
      logic [1:0]  fault;
   } gp_status_type;

   class grace_period_scoreboard;
      logic [3:0]    online_cfg;
      logic [31:0]   gen_counter;
      bit            in_period;
      logic [31:0]   closed_gen;
      logic [7:0]    qs_mask;
      bit            owes_qs [CPUS];
      logic [15:0]   nest_depth [CPUS];
      bit            holds_cbs [CPUS];
      logic [31:0]   oldest_cb_gen [CPUS];
      bit            ended_now;
      gp_status_type awaited_status [$];
      int            fails;

      function new();
         online_cfg    = 4'(rgpt_pkg::ACTIVE_CPUS_RESET);
         gen_counter   = '0;
         in_period     = 1'b0;
         closed_gen    = '0;
         qs_mask       = '0;
         ended_now     = 1'b0;
         fails         = 0;
         for (int i = 0; i < CPUS; i++) begin
            owes_qs[i]       = 1'b0;
            nest_depth[i]    = '0;
            holds_cbs[i]     = 1'b0;
            oldest_cb_gen[i] = '1;
         end
      endfunction

      function int unsigned online_count();
         int unsigned n;
         n = online_cfg;
         if (n == 0) n = 1;
         if (n > CPUS) n = CPUS;
         return n;
      endfunction

      function logic [7:0] online_bits();
         return 8'((16'd1 << online_count()) - 16'd1);
      endfunction

      function void open_period();
         gen_counter = gen_counter + 32'd1;
         in_period   = 1'b1;
         qs_mask     = online_bits();
      endfunction

      function void report_quiescent(int unsigned c);
         if (!owes_qs[c]) return;
         qs_mask[c] = 1'b0;
         owes_qs[c] = 1'b0;
         if ((qs_mask & online_bits()) == 8'd0 && in_period) begin
            closed_gen  = gen_counter;
            gen_counter = gen_counter + 32'd1;
            in_period   = 1'b0;
            ended_now   = 1'b1;
         end
      endfunction

      function void mark_cpu(int unsigned c);
         if (!in_period) return;
         if (!owes_qs[c]) begin
            owes_qs[c] = 1'b1;
            if (nest_depth[c] == 0) report_quiescent(c);
         end
      endfunction

      function void queue_callback(int unsigned c, logic [31:0] g);
         if (g < oldest_cb_gen[c]) oldest_cb_gen[c] = g;
         holds_cbs[c] = 1'b1;
      endfunction

      function void apply_command(logic [2:0] cmd, logic [2:0] c, logic [2:0] d,
                                  logic [15:0] nest, logic [31:0] rq);
         logic [31:0]         cb_gen;
         logic                submit;
         rgpt_pkg::fault_type fault;
         bit                  was_idle;
         gp_status_type       st;
         cb_gen    = '0;
         submit    = 1'b0;
         fault     = rgpt_pkg::FAULT_OK;
         ended_now = 1'b0;
         if (cmd <= rgpt_pkg::CMD_REQUEUE &&
             (c >= online_count() ||
              (cmd == rgpt_pkg::CMD_MIGRATE && d >= online_count()))) begin
            fault = rgpt_pkg::FAULT_BAD_CPU;
         end else begin
            case (cmd)
               rgpt_pkg::CMD_READ_LOCK: begin
                  if (nest_depth[c] == DEPTH_FULL) begin
                     fault = rgpt_pkg::FAULT_OVERFLOW;
                  end else begin
                     if (nest_depth[c] == 0 && in_period && !owes_qs[c]) begin
                        owes_qs[c] = 1'b1;
                        qs_mask[c] = 1'b1;
                     end
                     nest_depth[c] = nest_depth[c] + 16'd1;
                  end
               end
               rgpt_pkg::CMD_READ_UNLOCK: begin
                  if (nest_depth[c] == 0) fault = rgpt_pkg::FAULT_UNDERFLOW;
                  else nest_depth[c] = nest_depth[c] - 16'd1;
               end
               rgpt_pkg::CMD_REGISTER_CB: begin
                  was_idle = !in_period;
                  cb_gen   = was_idle ? gen_counter + 32'd1 : gen_counter;
                  queue_callback(c, cb_gen);
                  if (was_idle) begin
                     open_period();
                     mark_cpu(c);
                  end
               end
               rgpt_pkg::CMD_TICK: begin
                  if (owes_qs[c] && nest_depth[c] == 0) report_quiescent(c);
                  if (holds_cbs[c] && oldest_cb_gen[c] <= closed_gen) begin
                     holds_cbs[c]     = 1'b0;
                     oldest_cb_gen[c] = '1;
                     submit           = 1'b1;
                  end
                  mark_cpu(c);
                  if (!in_period && holds_cbs[c]) begin
                     open_period();
                     mark_cpu(c);
                  end
               end
               rgpt_pkg::CMD_MIGRATE: begin
                  if (nest != 0) begin
                     if (nest_depth[c] < nest) begin
                        fault = rgpt_pkg::FAULT_UNDERFLOW;
                     end else if (c != d &&
                                  (17'(nest_depth[d]) + 17'(nest)) > 17'(DEPTH_FULL)) begin
                        fault = rgpt_pkg::FAULT_OVERFLOW;
                     end else begin
                        if (nest_depth[d] == 0) begin
                           owes_qs[d] = 1'b1;
                           qs_mask[d] = 1'b1;
                        end
                        if (c != d) begin
                           nest_depth[d] = nest_depth[d] + nest;
                           nest_depth[c] = nest_depth[c] - nest;
                        end
                     end
                  end
               end
               rgpt_pkg::CMD_REQUEUE: queue_callback(c, rq);
               default: ;
            endcase
         end
         st.gp_generation        = gen_counter;
         st.gp_ongoing           = in_period;
         st.completed_generation = closed_gen;
         st.callback_generation  = cb_gen;
         st.submit_callbacks     = submit;
         st.period_done          = ended_now;
         st.fault                = fault;
         awaited_status.push_back(st);
      endfunction

      function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
         end
      endfunction

      function void check_response(gp_status_type got);
         gp_status_type want;
         if (awaited_status.size() == 0) begin
            $error("response with no request outstanding");
            fails++;
            return;
         end
         want = awaited_status.pop_front();
         compare_field("gp_generation", want.gp_generation, got.gp_generation);
         compare_field("gp_ongoing", want.gp_ongoing, got.gp_ongoing);
         compare_field("completed_generation", want.completed_generation,
                       got.completed_generation);
         compare_field("callback_generation", want.callback_generation,
                       got.callback_generation);
         compare_field("submit_callbacks", want.submit_callbacks, got.submit_callbacks);
         compare_field("period_done", want.period_done, got.period_done);
         compare_field("fault", want.fault, got.fault);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [2:0]  req_cpu = '0;
   logic [2:0]  req_dst_cpu = '0;
   logic [15:0] req_task_nesting = '0;
   logic [31:0] req_requeue_generation = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_gp_generation;
   logic        rsp_gp_ongoing;
   logic [31:0] rsp_completed_generation;
   logic [31:0] rsp_callback_generation;
   logic        rsp_submit_callbacks;
   logic        rsp_period_done;
   logic [1:0]  rsp_fault;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_active_cpus = '0;

   grace_period_scoreboard sb;
   bit          hold_long = 1'b0;
   bit          steady_feed = 1'b0;
   int unsigned burst_left = 0;
   int          quiet_cycles = 0;

   rcu_grace_period_tracker uut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_command              (req_command),
      .req_cpu                  (req_cpu),
      .req_dst_cpu              (req_dst_cpu),
      .req_task_nesting         (req_task_nesting),
      .req_requeue_generation   (req_requeue_generation),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_gp_generation        (rsp_gp_generation),
      .rsp_gp_ongoing           (rsp_gp_ongoing),
      .rsp_completed_generation (rsp_completed_generation),
      .rsp_callback_generation  (rsp_callback_generation),
      .rsp_submit_callbacks     (rsp_submit_callbacks),
      .rsp_period_done          (rsp_period_done),
      .rsp_fault                (rsp_fault),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_active_cpus          (csr_active_cpus)
   );

   always #5 clock = ~clock;

   // handshake signals are stable from the falling edge to the next rising edge
   always @(negedge clock) begin
      gp_status_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.gp_generation        = rsp_gp_generation;
         got.gp_ongoing           = rsp_gp_ongoing;
         got.completed_generation = rsp_completed_generation;
         got.callback_generation  = rsp_callback_generation;
         got.submit_callbacks     = rsp_submit_callbacks;
         got.period_done          = rsp_period_done;
         got.fault                = rsp_fault;
         sb.check_response(got);
      end
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : receiver
      int unsigned mode;
      int unsigned left;
      bit          toggle;
      mode   = 0;
      left   = 0;
      toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 80);
         end
         left--;
         toggle = !toggle;
         case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= toggle;
         endcase
      end
   end

   task automatic issue(input logic [2:0] cmd, input logic [2:0] cpu, input logic [2:0] dst,
                        input logic [15:0] nest, input logic [31:0] rq);
      int unsigned gap;
      bit          taken;
      if (burst_left == 0) begin
         gap = steady_feed ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid              <= 1'b1;
      req_command            <= cmd;
      req_cpu                <= cpu;
      req_dst_cpu            <= dst;
      req_task_nesting       <= nest;
      req_requeue_generation <= rq;
      forever begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
         if (taken) break;
      end
      sb.apply_command(cmd, cpu, dst, nest, rq);
      burst_left--;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.awaited_status.size() != 0);
   endtask

   task automatic write_active_cpus(input logic [3:0] value);
      bit taken;
      csr_valid       <= 1'b1;
      csr_active_cpus <= value;
      forever begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
         if (taken) break;
      end
      csr_valid <= 1'b0;
      sb.online_cfg = value;
   endtask

   task automatic directed_checks();
      issue(rgpt_pkg::CMD_TICK, 3'd0, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_READ_LOCK, 3'd0, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_READ_UNLOCK, 3'd0, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_READ_UNLOCK, 3'd0, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_MIGRATE, 3'd0, 3'd1, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_MIGRATE, 3'd7, 3'd7, DEPTH_FULL, 32'hFFFF_FFFF);
      // readers moved while no period runs still leave a report owed
      issue(rgpt_pkg::CMD_READ_LOCK, 3'd2, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_MIGRATE, 3'd2, 3'd3, 16'd1, 32'd0);
      issue(rgpt_pkg::CMD_MIGRATE, 3'd3, 3'd2, 16'd1, 32'd0);
      issue(rgpt_pkg::CMD_REGISTER_CB, 3'd1, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_REGISTER_CB, 3'd4, 3'd0, 16'd0, 32'd0);
      // callback put back with a generation that has already completed
      issue(rgpt_pkg::CMD_REQUEUE, 3'd5, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_TICK, 3'd5, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_REQUEUE, 3'd6, 3'd0, 16'd0, 32'hFFFF_FFFF);
      issue(CMD_SPARE_A, 3'd7, 3'd7, DEPTH_FULL, 32'hFFFF_FFFF);
      issue(CMD_SPARE_B, 3'd0, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_READ_UNLOCK, 3'd2, 3'd0, 16'd0, 32'd0);
      for (int i = 0; i < CPUS; i++) issue(rgpt_pkg::CMD_TICK, 3'(i), 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_TICK, 3'd1, 3'd0, 16'd0, 32'd0);
      issue(rgpt_pkg::CMD_TICK, 3'd4, 3'd0, 16'd0, 32'd0);
   endtask

   task automatic random_request();
      int unsigned n;
      int unsigned roll;
      int unsigned pick;
      logic [2:0]  cmd;
      logic [2:0]  c;
      logic [2:0]  d;
      logic [15:0] nest;
      logic [31:0] rq;
      n    = sb.online_count();
      roll = $urandom_range(0, 99);
      c    = 3'($urandom_range(0, n - 1));
      d    = 3'($urandom_range(0, n - 1));
      nest = 16'($urandom);
      rq   = $urandom;
      if (roll < 3) begin
         cmd = $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
         c   = 3'($urandom);
      end else if (roll < 10) begin
         cmd = 3'($urandom_range(0, 5));
         c   = 3'($urandom);
         d   = 3'($urandom);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            cmd = rgpt_pkg::CMD_TICK;
         end else if (pick < 55) begin
            cmd = (sb.nest_depth[c] < 4) ? rgpt_pkg::CMD_READ_LOCK
                                         : rgpt_pkg::CMD_READ_UNLOCK;
         end else if (pick < 72) begin
            cmd = rgpt_pkg::CMD_READ_UNLOCK;
         end else if (pick < 82) begin
            cmd = rgpt_pkg::CMD_REGISTER_CB;
         end else if (pick < 92) begin
            cmd  = rgpt_pkg::CMD_MIGRATE;
            nest = 16'($urandom_range(0, sb.nest_depth[c] + 1));
         end else begin
            cmd = rgpt_pkg::CMD_REQUEUE;
            case ($urandom_range(0, 2))
               0:       rq = $urandom_range(0, sb.closed_gen);
               1:       rq = sb.gen_counter + $urandom_range(0, 3);
               default: ;
            endcase
         end
      end
      issue(cmd, c, d, nest, rq);
   endtask

   task automatic random_phase(input int count, input bit with_hold, input bit pause_midway);
      if (with_hold) hold_long = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) wait_for_responses();
         random_request();
      end
   endtask

   // releases every reader still held on each CPU, requests back to back
   task automatic drain_nesting();
      steady_feed = 1'b1;
      for (int i = 0; i < CPUS; i++)
         while (sb.nest_depth[i] != 0)
            issue(rgpt_pkg::CMD_READ_UNLOCK, 3'(i), 3'd0, 16'd0, 32'd0);
      steady_feed = 1'b0;
   endtask

   initial begin
      logic [3:0] cfg_values [9];
      cfg_values = '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd9, 4'd2, 4'd8};
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_active_cpus(4'd8);
      directed_checks();
      foreach (cfg_values[i]) begin
         wait_for_responses();
         write_active_cpus(cfg_values[i]);
         random_phase(50, i == 2, i == 4);
      end
      wait_for_responses();
      write_active_cpus(4'd8);
      drain_nesting();
      random_phase(40, 1'b0, 1'b0);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fails == 0 && sb.awaited_status.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rgpt_pkg.sv
rtl/core/rcu_grace_period_tracker.sv
tb/tb_top.sv
